[rtl/mhtq_pkg.sv]
// Package: constants, types and controller/datapath interface for the timer queue.
`timescale 1ns / 1ps
`default_nettype none
package mhtq_pkg;

  localparam int CAPACITY    = 64;
  localparam int ID_BITS     = 8;
  localparam int MAX_RESULTS = 64;
  localparam int ID_COUNT    = 1 << ID_BITS;
  localparam int HW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int LW          = HW + 2;
  localparam int FW          = $clog2(MAX_RESULTS);
  localparam int NW          = $clog2(MAX_RESULTS + 1);
  localparam int DLW         = 64;
  localparam int PERW        = 32;
  localparam int OIDW        = 8;
  localparam int IN_DW       = 104;
  localparam int OUT_DW      = 152;

  typedef enum logic [1:0] {
    FN_ADD  = 2'd0,
    FN_DEL  = 2'd1,
    FN_FIRE = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DELETED   = 3'd1,
    ST_FIRED     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef struct packed {
    logic [DLW-1:0]     dl;
    logic [PERW-1:0]    per;
    logic [ID_BITS-1:0] own;
  } entry_t;

  typedef struct packed {
    entry_t             e;
    logic               rok;
    logic [ID_BITS-1:0] rid;
  } fired_t;

  typedef enum logic [2:0] {
    RA_PARENT, RA_LEFT, RA_RIGHT, RA_LAST, RA_ZERO
  } raddr_sel_t;

  typedef enum logic [1:0] {
    HW_X, HW_RD, HW_CHILD
  } hwr_sel_t;

  typedef enum logic [2:0] {
    P_HOLD, P_PARENT, P_CHILD, P_ZERO, P_SLOT
  } pos_sel_t;

  typedef enum logic [1:0] {
    X_HOLD, X_RD
  } x_sel_t;

  typedef enum logic [1:0] {
    RID_ZERO, RID_NID, RID_TGT
  } rid_sel_t;

  typedef enum logic [1:0] {
    RET_DONE, RET_FIRE, RET_REARM
  } ret_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_CHK, S_D_CHK, S_D_POS, S_F_CHK, S_F_TOP, S_F_RD, S_F_GET,
    S_REM, S_REM_X, S_SU_RD, S_SU_CMP, S_SD_RDL, S_SD_RDR, S_SD_CMP, S_WRX,
    S_RA_RD, S_RA_CHK, S_TOP_RD, S_TOP_LD, S_OUT1, S_FO_RD, S_FO_LD
  } state_t;

  typedef struct packed {
    logic       in_rdy;
    logic       h_re;
    raddr_sel_t h_raddr;
    logic       h_we;
    hwr_sel_t   h_wsel;
    pos_sel_t   pos_sel;
    x_sel_t     x_sel;
    logic       add_new;
    logic       add_rearm;
    logic       cnt_dec;
    logic       vld_clr_tgt;
    logic       vld_clr_rd;
    logic       s_re;
    logic       l_ld;
    logic       top_ld;
    logic       f_we_new;
    logic       f_we_rearm;
    logic       f_re;
    logic       n_clr;
    logic       n_inc;
    logic       k_clr;
    logic       k_inc;
    logic       res_ld;
    status_t    res_code;
    rid_sel_t   rid_sel;
    logic       adl_ld;
    logic       out_ld_single;
    logic       out_ld_fire;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    func_t in_func;
    logic  cnt_zero;
    logic  cnt_full;
    logic  vld_nid;
    logic  vld_tgt;
    logic  pos_zero;
    logic  pos_last;
    logic  x_lt_rd;
    logic  x_lt_c;
    logic  l_ge_cnt;
    logic  n_max;
    logic  rd_eq_top;
    logic  k_eq_n;
    logic  k_last;
    logic  f_per_nz;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/mhtq_datapath.sv]
// Datapath: heap, slot table, fired-timer buffer, work registers and output register.
`timescale 1ns / 1ps
`default_nettype none
module mhtq_datapath
  import mhtq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,
  input  wire logic [1:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  // storage
  entry_t           hmem [CAPACITY];
  logic [HW-1:0]    smem [ID_COUNT];
  fired_t           fmem [MAX_RESULTS];

  // control registers
  logic [CW-1:0]       cnt_r;
  logic [ID_BITS-1:0]  nid_r;
  logic [ID_COUNT-1:0] vld_r;
  logic [NW-1:0]       n_r;
  logic [NW-1:0]       k_r;
  logic                out_valid_r;

  // payload registers
  entry_t             h_rd_r;
  logic [HW-1:0]      s_rd_r;
  fired_t             f_rd_r;
  entry_t             x_r;
  entry_t             l_r;
  logic               hr_r;
  logic [HW-1:0]      pos_r;
  logic [DLW-1:0]     dl_in_r;
  logic [PERW-1:0]    per_in_r;
  logic [ID_BITS-1:0] tgt_r;
  logic [DLW-1:0]     top_r;
  status_t            res_st_r;
  logic [ID_BITS-1:0] res_id_r;
  logic [DLW-1:0]     adl_r;
  status_t            o_st_r;
  logic [OIDW-1:0]    o_rid_r;
  logic [DLW-1:0]     o_fdl_r;
  logic               o_rok_r;
  logic [OIDW-1:0]    o_rearm_r;
  logic               o_armed_r;
  logic [DLW-1:0]     o_adl_r;
  logic               o_last_r;

  logic               acc;
  logic [HW-1:0]      parent_a;
  logic [LW-1:0]      left_w;
  logic [LW-1:0]      right_w;
  logic [LW-1:0]      cnt_w;
  logic [HW-1:0]      last_a;
  logic               use_r;
  entry_t             c_e;
  logic [HW-1:0]      c_pos;
  logic [HW-1:0]      h_raddr;
  entry_t             h_wd;
  entry_t             x_add;
  fired_t             f_wd;
  logic [FW-1:0]      f_waddr;
  logic [NW-1:0]      k_inc_w;

  assign acc       = in_tvalid && cmd.in_rdy;
  assign in_tready = cmd.in_rdy;

  // heap addressing
  assign parent_a = (pos_r - HW'(1)) >> 1;
  assign left_w   = {1'b0, pos_r, 1'b1};
  assign right_w  = left_w + LW'(1);
  assign cnt_w    = LW'(cnt_r);
  assign last_a   = HW'(cnt_r - CW'(1));

  // pick the smaller child; a tie goes right
  assign use_r = hr_r && !(l_r.dl < h_rd_r.dl);
  assign c_e   = use_r ? h_rd_r : l_r;
  assign c_pos = use_r ? right_w[HW-1:0] : left_w[HW-1:0];

  always_comb begin
    case (cmd.h_raddr)
      RA_PARENT: h_raddr = parent_a;
      RA_LEFT:   h_raddr = left_w[HW-1:0];
      RA_RIGHT:  h_raddr = right_w[HW-1:0];
      RA_LAST:   h_raddr = last_a;
      default:   h_raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.h_wsel)
      HW_RD:    h_wd = h_rd_r;
      HW_CHILD: h_wd = c_e;
      default:  h_wd = x_r;
    endcase
  end

  // new entry for an add or a periodic re-add
  always_comb begin
    x_add.own = nid_r;
    if (cmd.add_rearm) begin
      x_add.dl  = f_rd_r.e.dl + DLW'(f_rd_r.e.per);
      x_add.per = f_rd_r.e.per;
    end else begin
      x_add.dl  = dl_in_r;
      x_add.per = per_in_r;
    end
  end

  always_comb begin
    if (cmd.f_we_rearm) begin
      f_wd    = '{e: f_rd_r.e, rok: 1'b1, rid: nid_r};
      f_waddr = k_r[FW-1:0];
    end else begin
      f_wd    = '{e: h_rd_r, rok: 1'b0, rid: '0};
      f_waddr = n_r[FW-1:0];
    end
  end

  // heap and slot table
  always_ff @(posedge clk) begin
    if (cmd.h_we) begin
      hmem[pos_r]    <= h_wd;
      smem[h_wd.own] <= pos_r;
    end
    if (cmd.h_re) begin
      h_rd_r <= hmem[h_raddr];
    end
    if (cmd.s_re) begin
      s_rd_r <= smem[tgt_r];
    end
  end

  // fired-timer buffer
  always_ff @(posedge clk) begin
    if (cmd.f_we_new || cmd.f_we_rearm) begin
      fmem[f_waddr] <= f_wd;
    end
    if (cmd.f_re) begin
      f_rd_r <= fmem[k_r[FW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nid_r       <= '0;
      vld_r       <= '0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add_new) begin
        cnt_r        <= cnt_r + CW'(1);
        nid_r        <= nid_r + ID_BITS'(1);
        vld_r[nid_r] <= 1'b1;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.vld_clr_tgt) begin
        vld_r[tgt_r] <= 1'b0;
      end
      if (cmd.vld_clr_rd) begin
        vld_r[h_rd_r.own] <= 1'b0;
      end
      if (cmd.n_clr) begin
        n_r <= '0;
      end else if (cmd.n_inc) begin
        n_r <= n_r + NW'(1);
      end
      if (cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_inc_w;
      end
      if (cmd.out_ld_single || cmd.out_ld_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign k_inc_w = k_r + NW'(1);

  // work registers
  always_ff @(posedge clk) begin
    if (acc) begin
      dl_in_r  <= in_tdata[63:0];
      per_in_r <= in_tdata[95:64];
      tgt_r    <= ID_BITS'(in_tdata[103:96]);
    end
    if (cmd.add_new) begin
      x_r   <= x_add;
      pos_r <= cnt_r[HW-1:0];
    end else begin
      if (cmd.x_sel == X_RD) begin
        x_r <= h_rd_r;
      end
      case (cmd.pos_sel)
        P_PARENT: pos_r <= parent_a;
        P_CHILD:  pos_r <= c_pos;
        P_ZERO:   pos_r <= '0;
        P_SLOT:   pos_r <= s_rd_r;
        default:  pos_r <= pos_r;
      endcase
    end
    if (cmd.l_ld) begin
      l_r  <= h_rd_r;
      hr_r <= right_w < cnt_w;
    end
    if (cmd.top_ld) begin
      top_r <= h_rd_r.dl;
    end
    if (cmd.res_ld) begin
      res_st_r <= cmd.res_code;
      case (cmd.rid_sel)
        RID_NID: res_id_r <= nid_r;
        RID_TGT: res_id_r <= tgt_r;
        default: res_id_r <= '0;
      endcase
    end
    if (cmd.adl_ld) begin
      adl_r <= (cnt_r == '0) ? '0 : h_rd_r.dl;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld_single) begin
      o_st_r    <= res_st_r;
      o_rid_r   <= OIDW'(res_id_r);
      o_fdl_r   <= '0;
      o_rok_r   <= 1'b0;
      o_rearm_r <= '0;
      o_armed_r <= cnt_r != '0;
      o_adl_r   <= adl_r;
      o_last_r  <= 1'b1;
    end else if (cmd.out_ld_fire) begin
      o_st_r    <= ST_FIRED;
      o_rid_r   <= OIDW'(f_rd_r.e.own);
      o_fdl_r   <= f_rd_r.e.dl;
      o_rok_r   <= f_rd_r.rok;
      o_rearm_r <= OIDW'(f_rd_r.rid);
      o_armed_r <= cnt_r != '0;
      o_adl_r   <= adl_r;
      o_last_r  <= k_inc_w == n_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {6'd0, o_adl_r, o_armed_r, o_rearm_r, o_rok_r, o_fdl_r, o_rid_r};

  // status to the controller
  always_comb begin
    sts.in_valid  = in_tvalid;
    sts.in_func   = func_t'(in_tuser);
    sts.cnt_zero  = cnt_r == '0;
    sts.cnt_full  = cnt_r >= CW'(CAPACITY);
    sts.vld_nid   = vld_r[nid_r];
    sts.vld_tgt   = vld_r[tgt_r];
    sts.pos_zero  = pos_r == '0;
    sts.pos_last  = CW'(pos_r) == (cnt_r - CW'(1));
    sts.x_lt_rd   = x_r.dl < h_rd_r.dl;
    sts.x_lt_c    = x_r.dl < c_e.dl;
    sts.l_ge_cnt  = left_w >= cnt_w;
    sts.n_max     = n_r == NW'(MAX_RESULTS);
    sts.rd_eq_top = h_rd_r.dl == top_r;
    sts.k_eq_n    = k_r == n_r;
    sts.k_last    = k_inc_w == n_r;
    sts.f_per_nz  = f_rd_r.e.per != '0;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule
`default_nettype wire

[rtl/mhtq_ctrl.sv]
// Controller: sequences add, delete, fire, heap sifts and result beats.
`timescale 1ns / 1ps
`default_nettype none
module mhtq_ctrl
  import mhtq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic   sdok_r, sdok_nxt;
  logic   moved_r, moved_nxt;
  logic   multi_r, multi_nxt;
  state_t ret_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= RET_DONE;
      sdok_r  <= 1'b0;
      moved_r <= 1'b0;
      multi_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      sdok_r  <= sdok_nxt;
      moved_r <= moved_nxt;
      multi_r <= multi_nxt;
    end
  end

  // where a finished sift or removal resumes
  always_comb begin
    case (ret_r)
      RET_FIRE:  ret_state = S_F_RD;
      RET_REARM: ret_state = S_RA_RD;
      default:   ret_state = S_TOP_RD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    sdok_nxt  = sdok_r;
    moved_nxt = moved_r;
    multi_nxt = multi_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_valid) begin
          multi_nxt = 1'b0;
          case (sts.in_func)
            FN_ADD:  state_nxt = S_A_CHK;
            FN_DEL:  state_nxt = S_D_CHK;
            FN_FIRE: state_nxt = S_F_CHK;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // add: place at the end, sift up
      S_A_CHK: begin
        cmd.res_ld = 1'b1;
        if (sts.cnt_full || sts.vld_nid) begin
          cmd.res_code = ST_FULL;
          cmd.rid_sel  = RID_ZERO;
          state_nxt    = S_TOP_RD;
        end else begin
          cmd.res_code = ST_ADDED;
          cmd.rid_sel  = RID_NID;
          cmd.add_new  = 1'b1;
          ret_nxt      = RET_DONE;
          sdok_nxt     = 1'b0;
          moved_nxt    = 1'b0;
          state_nxt    = S_SU_RD;
        end
      end
      // delete: look up the slot, then remove it
      S_D_CHK: begin
        if (!sts.vld_tgt) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
          cmd.rid_sel  = RID_TGT;
          state_nxt    = S_TOP_RD;
        end else begin
          cmd.s_re  = 1'b1;
          state_nxt = S_D_POS;
        end
      end
      S_D_POS: begin
        cmd.pos_sel     = P_SLOT;
        cmd.vld_clr_tgt = 1'b1;
        cmd.res_ld      = 1'b1;
        cmd.res_code    = ST_DELETED;
        cmd.rid_sel     = RID_TGT;
        ret_nxt         = RET_DONE;
        state_nxt       = S_REM;
      end
      // fire: note the earliest deadline, pop while equal
      S_F_CHK: begin
        if (sts.cnt_zero) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = ST_NONE;
          cmd.rid_sel  = RID_ZERO;
          state_nxt    = S_TOP_RD;
        end else begin
          cmd.h_re    = 1'b1;
          cmd.h_raddr = RA_ZERO;
          cmd.n_clr   = 1'b1;
          multi_nxt   = 1'b1;
          state_nxt   = S_F_TOP;
        end
      end
      S_F_TOP: begin
        cmd.top_ld = 1'b1;
        state_nxt  = S_F_RD;
      end
      S_F_RD: begin
        if (sts.cnt_zero || sts.n_max) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_RA_RD;
        end else begin
          cmd.h_re    = 1'b1;
          cmd.h_raddr = RA_ZERO;
          state_nxt   = S_F_GET;
        end
      end
      S_F_GET: begin
        if (!sts.rd_eq_top) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_RA_RD;
        end else begin
          cmd.f_we_new   = 1'b1;
          cmd.n_inc      = 1'b1;
          cmd.vld_clr_rd = 1'b1;
          cmd.pos_sel    = P_ZERO;
          ret_nxt        = RET_FIRE;
          state_nxt      = S_REM;
        end
      end
      // removal: move the last entry into the hole
      S_REM: begin
        if (sts.pos_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = ret_state;
        end else begin
          cmd.h_re    = 1'b1;
          cmd.h_raddr = RA_LAST;
          state_nxt   = S_REM_X;
        end
      end
      S_REM_X: begin
        cmd.x_sel   = X_RD;
        cmd.cnt_dec = 1'b1;
        moved_nxt   = 1'b0;
        sdok_nxt    = 1'b1;
        state_nxt   = S_SU_RD;
      end
      // sift up
      S_SU_RD: begin
        if (sts.pos_zero) begin
          state_nxt = (moved_r || !sdok_r) ? S_WRX : S_SD_RDL;
        end else begin
          cmd.h_re    = 1'b1;
          cmd.h_raddr = RA_PARENT;
          state_nxt   = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (sts.x_lt_rd) begin
          cmd.h_we    = 1'b1;
          cmd.h_wsel  = HW_RD;
          cmd.pos_sel = P_PARENT;
          moved_nxt   = 1'b1;
          state_nxt   = S_SU_RD;
        end else begin
          state_nxt = (moved_r || !sdok_r) ? S_WRX : S_SD_RDL;
        end
      end
      // sift down
      S_SD_RDL: begin
        if (sts.l_ge_cnt) begin
          state_nxt = S_WRX;
        end else begin
          cmd.h_re    = 1'b1;
          cmd.h_raddr = RA_LEFT;
          state_nxt   = S_SD_RDR;
        end
      end
      S_SD_RDR: begin
        cmd.l_ld    = 1'b1;
        cmd.h_re    = 1'b1;
        cmd.h_raddr = RA_RIGHT;
        state_nxt   = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (sts.x_lt_c) begin
          state_nxt = S_WRX;
        end else begin
          cmd.h_we    = 1'b1;
          cmd.h_wsel  = HW_CHILD;
          cmd.pos_sel = P_CHILD;
          state_nxt   = S_SD_RDL;
        end
      end
      S_WRX: begin
        cmd.h_we   = 1'b1;
        cmd.h_wsel = HW_X;
        state_nxt  = ret_state;
      end
      // re-add periodic timers in firing order
      S_RA_RD: begin
        if (sts.k_eq_n) begin
          state_nxt = S_TOP_RD;
        end else begin
          cmd.f_re  = 1'b1;
          state_nxt = S_RA_CHK;
        end
      end
      S_RA_CHK: begin
        cmd.k_inc = 1'b1;
        if (sts.f_per_nz && !sts.cnt_full && !sts.vld_nid) begin
          cmd.f_we_rearm = 1'b1;
          cmd.add_new    = 1'b1;
          cmd.add_rearm  = 1'b1;
          ret_nxt        = RET_REARM;
          sdok_nxt       = 1'b0;
          moved_nxt      = 1'b0;
          state_nxt      = S_SU_RD;
        end else begin
          state_nxt = S_RA_RD;
        end
      end
      // earliest pending deadline for the results
      S_TOP_RD: begin
        cmd.h_re    = 1'b1;
        cmd.h_raddr = RA_ZERO;
        state_nxt   = S_TOP_LD;
      end
      S_TOP_LD: begin
        cmd.adl_ld = 1'b1;
        if (multi_r) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_FO_RD;
        end else begin
          state_nxt = S_OUT1;
        end
      end
      S_OUT1: begin
        if (sts.out_free) begin
          cmd.out_ld_single = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      // one beat per fired timer
      S_FO_RD: begin
        cmd.f_re  = 1'b1;
        state_nxt = S_FO_LD;
      end
      S_FO_LD: begin
        if (sts.out_free) begin
          cmd.out_ld_fire = 1'b1;
          cmd.k_inc       = 1'b1;
          state_nxt       = sts.k_last ? S_IDLE : S_FO_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/min_heap_timer_queue_top.sv]
// Add puts the entry at the heap end and climbs it toward the root; delete of the last entry
// only shrinks the heap, else the last entry fills the hole and sifts down or up. Fire notes the
// root deadline, pops each entry with it (up to 64) into the fired-timer buffer, re-adds
// periodic ones in firing order, then gives one beat per fired timer, each after a buffer read.
// Throughput: one item at a time, the next taken in the cycle after its last beat loads;
// beats wait on a held output; the heap port and 6-level sift set it. Reset: sync, active low.
`timescale 1ns / 1ps
`default_nettype none
module min_heap_timer_queue_top
  import mhtq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // deadline[63:0], period[95:64], target_id[103:96]
  input  wire logic [IN_DW-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [1:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // result_id[7:0], fired_deadline[71:8], rearmed[72], rearm_id[80:73],
  // armed[81], armed_deadline[145:82], zero fill[151:146]
  output logic [OUT_DW-1:0]      out_tdata,
  // status[2:0]
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  cmd_t cmd;
  sts_t sts;

  mhtq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  mhtq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
